### hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha_pkg: shared types and constants for the sha-256 stream hash unit
// Round constants, initial hash values, payload structs and sequencer states.
// ---------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    localparam logic        FUNC_ABSORB = 1'b0;
    localparam logic        FUNC_FINISH = 1'b1;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [63:0] BLOCK_BITS  = 64'd512;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

### hw/rtl/sha_round.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha_round: one sha-256 round with its message schedule step
// Combinational round unit, shared by all 64 rounds of every block.
// ---------------------------------------------------------------------------
module sha_round (
    input  logic [31:0] i_vars [8],
    input  logic [31:0] i_sched [16],
    input  logic [5:0]  i_round,
    output logic [31:0] o_vars [8],
    output logic [31:0] o_w
);
    import sha_pkg::*;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] w15, w2, s0, s1, t1, t2, a, e;

    always_comb begin
        w15 = i_sched[4'(i_round + 6'd1)];
        w2  = i_sched[4'(i_round + 6'd14)];
        s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
        s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
        // schedule word, expanded from round 16 on
        if (i_round < 6'd16) begin
            o_w = i_sched[i_round[3:0]];
        end else begin
            o_w = i_sched[i_round[3:0]] + s0 + i_sched[4'(i_round + 6'd9)] + s1;
        end
        a  = i_vars[0];
        e  = i_vars[4];
        t1 = i_vars[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
           + ((e & i_vars[5]) ^ (~e & i_vars[6])) + ROUND_K[i_round] + o_w;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
           + ((a & i_vars[1]) ^ (a & i_vars[2]) ^ (i_vars[1] & i_vars[2]));
        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = t1 + t2;
    end

endmodule

### hw/rtl/sha256_stream_hash_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha256_stream_hash_unit: byte-stream sha-256 hasher
// Absorbs bytes into 16 schedule words, compresses full blocks, pads on finish.
// ---------------------------------------------------------------------------
// channel | direction | payload
// i_in    | input     | func, data_byte
// o_out   | output    | digest_word, word_index, last_word
//
// an absorb item writes one byte into the open block; the 64th byte of a block
// adds 64 rounds plus one hash update, all through the one shared round unit.
// a finish item takes one or two padding passes plus 8 digest items, each held
// until taken. reset restores the initial hash, zero length and an empty block.
// a stalled output holds the sequencer.
module sha256_stream_hash_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sha_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sha_pkg::t_out_item o_out_data
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_hash [8];
    logic [31:0] r_vars [8];
    logic [31:0] r_sched [16];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [5:0]  r_round;
    logic [2:0]  r_widx;
    logic        r_final;   // current padding block carries the length
    logic        r_finish;  // compression belongs to a finish

    logic [31:0] rnd_vars [8];
    logic [31:0] rnd_w;
    logic        in_acc;
    logic [63:0] msg_total;

    sha_round u_round (
        .i_vars (r_vars),
        .i_sched(r_sched),
        .i_round(r_round),
        .o_vars (rnd_vars),
        .o_w    (rnd_w)
    );

    assign in_acc = i_in_valid && o_in_ready;

    // message length in bits, including the bytes of the open block
    assign msg_total = r_bits + {55'd0, r_fill, 3'd0};

    // next state and handshake
    always_comb begin
        n_state     = r_state;
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_EMIT);
        o_out_data  = '{digest_word: r_hash[r_widx], word_index: r_widx,
                        last_word: (r_widx == 3'd7)};
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.func == FUNC_FINISH) begin
                        n_state = ST_PAD;
                    end else if (r_fill == 6'd63) begin
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_PAD:   n_state = ST_ROUND;
            ST_ROUND: if (r_round == 6'd63) n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (!r_finish) n_state = ST_IDLE;
                else if (r_final) n_state = ST_EMIT;
                else n_state = ST_PAD;
            end
            ST_EMIT: if (i_out_ready && r_widx == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_round  <= '0;
            r_widx   <= '0;
            r_final  <= 1'b0;
            r_finish <= 1'b0;
            r_hash   <= INIT_HASH;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_round <= '0;
                    if (in_acc) begin
                        r_finish <= (i_in_data.func == FUNC_FINISH);
                        if (i_in_data.func == FUNC_ABSORB) begin
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'd63) r_bits <= r_bits + BLOCK_BITS;
                        end else begin
                            r_final <= (r_fill < 6'd56);
                        end
                    end
                end
                ST_PAD: r_round <= '0;
                ST_ROUND: r_round <= r_round + 6'd1;
                ST_UPDATE: begin
                    for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_vars[i];
                    if (r_finish) r_final <= 1'b1;
                    r_widx <= '0;
                end
                ST_EMIT: begin
                    if (i_out_ready) begin
                        r_widx <= r_widx + 3'd1;
                        if (r_widx == 3'd7) begin
                            r_hash <= INIT_HASH;
                            r_fill <= '0;
                            r_bits <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // schedule words double as the block buffer; working variables
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.func == FUNC_ABSORB) begin
                        for (int b = 0; b < 4; b++) begin
                            if (r_fill[1:0] == 2'(b)) begin
                                r_sched[r_fill[5:2]][31-8*b -: 8] <= i_in_data.data_byte;
                            end
                        end
                    end else begin
                        // 0x80 at fill position, zero after it in this block
                        for (int j = 0; j < 64; j++) begin
                            if (6'(j) == r_fill) begin
                                r_sched[j/4][31-8*(j%4) -: 8] <= PAD_BYTE;
                            end else if (6'(j) > r_fill) begin
                                r_sched[j/4][31-8*(j%4) -: 8] <= 8'h00;
                            end
                        end
                    end
                    r_vars <= r_hash;
                end
            end
            ST_PAD: begin
                // second block is all zero; length words when this block is final
                if (r_final) begin
                    r_sched[14] <= msg_total[63:32];
                    r_sched[15] <= msg_total[31:0];
                end
                r_vars <= r_hash;
            end
            ST_ROUND: begin
                r_vars <= rnd_vars;
                if (r_round >= 6'd16) r_sched[r_round[3:0]] <= rnd_w;
            end
            ST_UPDATE: begin
                if (!r_final) begin
                    for (int k = 0; k < 16; k++) r_sched[k] <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the sha-256 stream hash unit
// Feeds byte and finish items with random gaps, predicts every digest word
// with a local sha-256 model and compares each output item in order.
// ---------------------------------------------------------------------------
module testbench;
    import sha_pkg::*;

    localparam int unsigned CycleLimit = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    sha256_stream_hash_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // predictor state
    logic [31:0] hash_st [8];
    logic [7:0]  blk_st [64];
    int unsigned fill_st;
    logic [63:0] bits_st;

    t_in_item    pending_items[$];
    t_out_item   digest_words_due[$];
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned items_sent;
    int unsigned words_seen;
    int unsigned messages_done;
    bit          stim_done;
    bit          hold_for_drain;
    int unsigned stall_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of blk_st into hash_st
    task automatic compress_block_model();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, t1, t2, s0, s1, a, e;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_st[4*i], blk_st[4*i+1], blk_st[4*i+2], blk_st[4*i+3]};
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                s0 = rotr(w[(r+1)&15], 7) ^ rotr(w[(r+1)&15], 18) ^ (w[(r+1)&15] >> 3);
                s1 = rotr(w[(r+14)&15], 17) ^ rotr(w[(r+14)&15], 19)
                     ^ (w[(r+14)&15] >> 10);
                wt = w[r&15] + s0 + w[(r+9)&15] + s1;
                w[r&15] = wt;
            end
            a = v[0];
            e = v[4];
            t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
                 + ((e & v[5]) ^ (~e & v[6])) + ROUND_K[r] + wt;
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
                 + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
    endtask

    task automatic hash_reset_model();
        for (int i = 0; i < 8; i++) hash_st[i] = INIT_HASH[i];
        fill_st = 0;
        bits_st = '0;
    endtask

    // append one item to the stimulus queue
    task automatic add_item(t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // predict the digest words caused by one accepted item
    task automatic predict_digest(t_in_item it);
        logic [63:0] total;
        int unsigned n;
        t_out_item   o;
        if (it.func == FUNC_ABSORB) begin
            blk_st[fill_st] = it.data_byte;
            fill_st++;
            if (fill_st == 64) begin
                compress_block_model();
                bits_st = bits_st + BLOCK_BITS;
                fill_st = 0;
            end
        end else begin
            total = bits_st + 64'(fill_st) * 64'd8;
            n = fill_st;
            blk_st[n] = PAD_BYTE;
            n++;
            if (n > 56) begin
                while (n < 64) begin blk_st[n] = 8'h00; n++; end
                compress_block_model();
                n = 0;
            end
            while (n < 56) begin blk_st[n] = 8'h00; n++; end
            for (int i = 0; i < 8; i++) blk_st[56+i] = total[63-8*i -: 8];
            compress_block_model();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_st[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_words_due.insert(digest_words_due.size(), o);
            end
            hash_reset_model();
        end
    endtask

    function automatic t_in_item byte_item(logic [7:0] b);
        t_in_item it;
        it.func = FUNC_ABSORB;
        it.data_byte = b;
        return it;
    endfunction

    function automatic t_in_item finish_item();
        t_in_item it;
        it.func = FUNC_FINISH;
        it.data_byte = 8'($urandom);
        return it;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stimulus plan
    initial begin
        int unsigned len;
        int unsigned kind;
        hash_reset_model();
        for (int i = 0; i < 64; i++) blk_st[i] = 8'h00;
        // empty message, data byte on finish ignored
        add_item(finish_item());
        // single extreme bytes
        add_item(byte_item(8'h00));
        add_item(finish_item());
        add_item(byte_item(8'hff));
        add_item(finish_item());
        // "abc"
        add_item(byte_item(8'h61));
        add_item(byte_item(8'h62));
        add_item(byte_item(8'h63));
        add_item(finish_item());
        // random messages; lengths near block and padding boundaries are favored
        while (pending_items.size() < 520) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) len = $urandom_range(54, 58);
            else if (kind < 5) len = $urandom_range(62, 66);
            else if (kind < 6) len = $urandom_range(118, 130);
            else len = $urandom_range(0, 20);
            for (int i = 0; i < len; i++) add_item(byte_item(8'($urandom)));
            add_item(finish_item());
        end
    end

    // driver
    int unsigned in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_digest(i_in_data);
                items_sent++;
                // sender pause until drained, once after a finish mid-run
                if (i_in_data.func == FUNC_FINISH && items_sent > 200 && !hold_for_drain
                    && messages_done == 0)
                    hold_for_drain = 1'b1;
                in_gap <= gap_len();
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (hold_for_drain && digest_words_due.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else if (i_in_valid && o_in_ready && gap_len() != 0) begin
                    i_in_valid <= 1'b0;
                end else if (!i_in_valid && in_gap != 0) begin
                    in_gap <= in_gap - 1;
                end else if (pending_items.size() != 0) begin
                    if (hold_for_drain) begin
                        hold_for_drain = 1'b0;
                        messages_done = 1;
                    end
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                    stim_done  <= 1'b1;
                end
            end
        end
    end

    // receiver ready with one long hold-off early in the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready  <= 1'b0;
            stall_cycles <= 0;
        end else if (cycle_count >= 400 && cycle_count < 1400) begin
            i_out_ready  <= 1'b0;
            stall_cycles <= stall_cycles + 1;
        end else begin
            i_out_ready <= (gap_len() == 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_seen++;
            if (digest_words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h idx %0d", o_out_data.digest_word,
                             o_out_data.word_index);
            end else begin
                exp_w = digest_words_due.pop_front();
                if (exp_w !== o_out_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                                 exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                                 o_out_data.digest_word, o_out_data.word_index,
                                 o_out_data.last_word);
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        mismatches = 0;
        items_sent = 0;
        words_seen = 0;
        messages_done = 0;
        hold_for_drain = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && digest_words_due.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("sent %0d items, checked %0d digest words, output held off %0d cycles",
                 items_sent, words_seen, stall_cycles);
        if (mismatches == 0 && digest_words_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, digest_words_due.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_round.sv
hw/rtl/sha256_stream_hash_unit.sv
tb/sv/testbench.sv
